// ===== src/hsl_to_rgb_converter_defines.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define HSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hsl_pkg.sv =====
package hsl_pkg;

  localparam int HUE_FRAC_BITS = 4;
  localparam int SL_FRAC_BITS  = 10;

  localparam int HUE_W = 15;
  localparam int SL_W  = 11;
  localparam int CH_W  = 8;

  localparam int HUE_TURN = 360 << HUE_FRAC_BITS;
  localparam int HUE_SECT = 60 << HUE_FRAC_BITS;
  localparam int SL_ONE   = 1 << SL_FRAC_BITS;

  // 255 / (2 * one^2 * sector) reduces to 17 / 2^shift
  localparam int CH_MUL   = 17;
  localparam int CH_SHIFT = 3 + 2 * SL_FRAC_BITS + HUE_FRAC_BITS;

  localparam int HW  = 13;  // wrapped hue, 0..5759
  localparam int AW  = 12;  // 1 - |2l - 1|
  localparam int CW  = 24;  // chroma
  localparam int TW  = 10;  // 0..960 triangle weight
  localparam int XW  = 35;  // chroma times weight
  localparam int WW  = 25;  // 2l - c
  localparam int VW  = 36;  // channel sum
  localparam int PW  = 41;  // channel sum times 17

  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  typedef struct packed {
    logic [HW-1:0]        hue;
    logic signed [AW-1:0] a;
    logic [SL_W-1:0]      sat;
    logic [SL_W-1:0]      lit;
  } s1_t;

  typedef struct packed {
    logic [2:0]           sector;
    logic signed [CW-1:0] c;
    logic [TW-1:0]        t;
    logic [SL_W-1:0]      lit;
  } s2_t;

  typedef struct packed {
    logic [2:0]           sector;
    logic signed [CW-1:0] c;
    logic signed [XW-1:0] ct;
    logic signed [WW-1:0] w;
  } s3_t;

endpackage

// ===== src/hsl_hue_wrap.sv =====
module hsl_hue_wrap (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hsl_pkg::HUE_W-1:0]  hue,
  input  logic [hsl_pkg::SL_W-1:0]   sat,
  input  logic [hsl_pkg::SL_W-1:0]   lit,
  output logic                       s1_valid,
  input  logic                       s1_ready,
  output hsl_pkg::s1_t               s1
);
  import hsl_pkg::*;

  logic              v1_r;
  logic              en1;
  s1_t               s1_r, s1_nxt;
  logic signed [15:0] h;
  logic signed [15:0] hw;
  logic signed [12:0] d;
  logic signed [12:0] dabs;

  assign en1 = !v1_r || s1_ready;
  assign in_ready = en1;
  assign s1_valid = v1_r;
  assign s1 = s1_r;

  always_comb begin
    h = 16'($signed(hue));
    priority if (h < -16'(2 * HUE_TURN)) begin
      hw = h + 16'(3 * HUE_TURN);
    end else if (h < -16'(HUE_TURN)) begin
      hw = h + 16'(2 * HUE_TURN);
    end else if (h < 16'sd0) begin
      hw = h + 16'(HUE_TURN);
    end else if (h < 16'(HUE_TURN)) begin
      hw = h;
    end else if (h < 16'(2 * HUE_TURN)) begin
      hw = h - 16'(HUE_TURN);
    end else begin
      hw = h - 16'(2 * HUE_TURN);
    end
    d = $signed({1'b0, lit, 1'b0}) - 13'(SL_ONE);
    dabs = (d < 13'sd0) ? -d : d;
    s1_nxt.hue = hw[HW-1:0];
    s1_nxt.a = AW'(13'(SL_ONE) - dabs);
    s1_nxt.sat = sat;
    s1_nxt.lit = lit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// ===== src/hsl_chroma.sv =====
module hsl_chroma (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  output logic          s1_ready,
  input  hsl_pkg::s1_t  s1,
  output logic          s3_valid,
  input  logic          s3_ready,
  output hsl_pkg::s3_t  s3
);
  import hsl_pkg::*;

  logic               v2_r, v3_r;
  logic               en2, en3;
  s2_t                s2_r, s2_nxt;
  s3_t                s3_r, s3_nxt;
  logic [10:0]        f;
  logic signed [11:0] fd;
  logic signed [11:0] fabs;

  assign en3 = !v3_r || s3_ready;
  assign en2 = !v2_r || en3;
  assign s1_ready = en2;
  assign s3_valid = v3_r;
  assign s3 = s3_r;

  // sector and position inside its double sector
  always_comb begin
    priority if (s1.hue < HW'(HUE_SECT)) begin
      s2_nxt.sector = SEC_RED_YEL;
      f = 11'(s1.hue);
    end else if (s1.hue < HW'(2 * HUE_SECT)) begin
      s2_nxt.sector = SEC_YEL_GRN;
      f = 11'(s1.hue);
    end else if (s1.hue < HW'(3 * HUE_SECT)) begin
      s2_nxt.sector = SEC_GRN_CYN;
      f = 11'(s1.hue - HW'(2 * HUE_SECT));
    end else if (s1.hue < HW'(4 * HUE_SECT)) begin
      s2_nxt.sector = SEC_CYN_BLU;
      f = 11'(s1.hue - HW'(2 * HUE_SECT));
    end else if (s1.hue < HW'(5 * HUE_SECT)) begin
      s2_nxt.sector = SEC_BLU_MAG;
      f = 11'(s1.hue - HW'(4 * HUE_SECT));
    end else begin
      s2_nxt.sector = SEC_MAG_RED;
      f = 11'(s1.hue - HW'(4 * HUE_SECT));
    end
    fd = $signed({1'b0, f}) - 12'(HUE_SECT);
    fabs = (fd < 12'sd0) ? -fd : fd;
    s2_nxt.t = TW'(12'(HUE_SECT) - fabs);
    s2_nxt.c = CW'(s1.a * $signed({1'b0, s1.sat}));
    s2_nxt.lit = s1.lit;
  end

  always_comb begin
    s3_nxt.sector = s2_r.sector;
    s3_nxt.c = s2_r.c;
    s3_nxt.ct = XW'(s2_r.c) * XW'($signed({1'b0, s2_r.t}));
    s3_nxt.w = $signed(WW'(s2_r.lit) << (SL_FRAC_BITS + 1)) - WW'(s2_r.c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= s1_valid;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r <= s2_nxt;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ===== src/hsl_channel.sv =====
`include "hsl_to_rgb_converter_defines.svh"

module hsl_channel (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s3_valid,
  output logic                      s3_ready,
  input  hsl_pkg::s3_t              s3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsl_pkg::CH_W-1:0]  red,
  output logic [hsl_pkg::CH_W-1:0]  green,
  output logic [hsl_pkg::CH_W-1:0]  blue
);
  import hsl_pkg::*;

  logic                 v4_r, v5_r;
  logic                 en4, en5;
  logic signed [VW-1:0] vr_r, vg_r, vb_r;
  logic signed [VW-1:0] vr_nxt, vg_nxt, vb_nxt;
  logic signed [VW-1:0] ms, cs, xs;
  logic [CH_W-1:0]      red_r, green_r, blue_r;

  function automatic logic [CH_W-1:0] to_channel(input logic signed [VW-1:0] v);
    logic signed [PW-1:0] p;
    p = PW'(v) * PW'(CH_MUL);
    if (v <= VW'(0)) begin
      to_channel = '0;
    end else if (p[PW-1:CH_SHIFT+CH_W] != '0) begin
      to_channel = '1;
    end else begin
      to_channel = p[CH_SHIFT+CH_W-1:CH_SHIFT];
    end
  endfunction

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign s3_ready = en4;
  assign out_valid = v5_r;
  assign red = red_r;
  assign green = green_r;
  assign blue = blue_r;

  always_comb begin
    ms = VW'(s3.w) * VW'(HUE_SECT);
    cs = VW'(s3.c) * VW'(2 * HUE_SECT);
    xs = VW'(s3.ct) <<< 1;
    unique case (s3.sector)
      SEC_RED_YEL: begin
        vr_nxt = ms + cs; vg_nxt = ms + xs; vb_nxt = ms;
      end
      SEC_YEL_GRN: begin
        vr_nxt = ms + xs; vg_nxt = ms + cs; vb_nxt = ms;
      end
      SEC_GRN_CYN: begin
        vr_nxt = ms; vg_nxt = ms + cs; vb_nxt = ms + xs;
      end
      SEC_CYN_BLU: begin
        vr_nxt = ms; vg_nxt = ms + xs; vb_nxt = ms + cs;
      end
      SEC_BLU_MAG: begin
        vr_nxt = ms + xs; vg_nxt = ms; vb_nxt = ms + cs;
      end
      default: begin
        vr_nxt = ms + cs; vg_nxt = ms; vb_nxt = ms + xs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) begin
        v4_r <= s3_valid;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      vr_r <= vr_nxt;
      vg_r <= vg_nxt;
      vb_r <= vb_nxt;
    end
    if (en5) begin
      red_r <= to_channel(vr_r);
      green_r <= to_channel(vg_r);
      blue_r <= to_channel(vb_r);
    end
  end

  `HSL_ASSERT_NOW(a_out_from_sum, $rose(v5_r), $past(v4_r), "output valid without a sum")
  `HSL_ASSERT_NEXT(a_sum_hold, v4_r && !en5, v4_r && $stable(vr_r), "stalled sum lost")

endmodule

// ===== src/hsl_to_rgb_converter.sv =====
// channel | dir | tdata bits                         | tuser | tlast
// in_     | in  | 14:0 hue, 25:15 sat, 36:26 light  | none  | none
// out_    | out | 7:0 red, 15:8 green, 23:16 blue   | none  | none
//
// one item per cycle while out_tready allows it, five register stages from input to output
// rst_n is synchronous and active low; it empties the pipeline
// a stall on out_tready holds the full stages, bubbles still close up
// in_tready falls only when every stage holds an item
`include "hsl_to_rgb_converter_defines.svh"

module hsl_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // hue, saturation, lightness, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red, green, blue
);
  import hsl_pkg::*;

  logic            s1_valid, s1_ready;
  logic            s3_valid, s3_ready;
  s1_t             s1;
  s3_t             s3;
  logic [CH_W-1:0] red, green, blue;

  hsl_hue_wrap u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .hue      (in_tdata[14:0]),
    .sat      (in_tdata[25:15]),
    .lit      (in_tdata[36:26]),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  hsl_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  hsl_channel u_channel (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3        (s3),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

  `HSL_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")
  `HSL_ASSERT_NOW(a_ready_on_take, out_tvalid && out_tready, in_tready, "input blocked on take")

endmodule

// ===== verif/tb_hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;
  import hsl_pkg::*;

  localparam int DIR_N   = 22;
  localparam int RAND_N  = 1330;
  localparam int PAD_W   = 40 - HUE_W - 2 * SL_W;
  localparam int HOLD_N  = 300;
  localparam int SETTLE  = 20;
  localparam int MAX_LOG = 100;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    int hue;
    int sat;
    int lit;
    bit known;
    int red;
    int green;
    int blue;
  } color_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  rgb_t rgb_expected_q [$];
  int   mismatch_count = 0;
  int   results_seen   = 0;
  int   burst_left     = 0;

  // hue, saturation, lightness, known, red, green, blue
  color_row_t color_rows [DIR_N] = '{
    '{0,      0,    0,    1, 0,   0,   0  },
    '{0,      0,    1024, 1, 255, 255, 255},
    '{0,      1024, 512,  1, 255, 0,   0  },
    '{960,    1024, 512,  1, 255, 255, 0  },
    '{1920,   1024, 512,  1, 0,   255, 0  },
    '{2880,   1024, 512,  1, 0,   255, 255},
    '{3840,   1024, 512,  1, 0,   0,   255},
    '{4800,   1024, 512,  1, 255, 0,   255},
    '{5760,   1024, 512,  1, 255, 0,   0  },
    '{-5760,  1024, 512,  1, 255, 0,   0  },
    '{11520,  1024, 512,  1, 255, 0,   0  },
    '{0,      0,    2047, 1, 255, 255, 255},
    '{11519,  1024, 512,  0, 0,   0,   0  },
    '{-1,     1024, 512,  0, 0,   0,   0  },
    '{16383,  2047, 2047, 0, 0,   0,   0  },
    '{-16384, 2047, 0,    0, 0,   0,   0  },
    '{5759,   1024, 512,  0, 0,   0,   0  },
    '{480,    512,  256,  0, 0,   0,   0  },
    '{1000,   2047, 512,  0, 0,   0,   0  },
    '{3000,   1024, 1536, 0, 0,   0,   0  },
    '{959,    1024, 1,    0, 0,   0,   0  },
    '{961,    1024, 1023, 0, 0,   0,   0  }
  };

  hsl_to_rgb_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [CH_W-1:0] channel_level(longint v);
    longint den;
    longint q;
    den = 2 * longint'(SL_ONE) * SL_ONE * HUE_SECT;
    if (v <= 0) begin
      return '0;
    end
    q = (255 * v) / den;
    if (q > 255) begin
      q = 255;
    end
    return q[CH_W-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb_predict(logic [HUE_W-1:0] hue, logic [SL_W-1:0] sat,
                                              logic [SL_W-1:0] lit);
    longint h, s, l, a, c, f, t, cs, xs, ms;
    logic [2:0] sector;
    rgb_t res;
    h = longint'(hue);
    if (hue[HUE_W-1]) begin
      h = h - (longint'(1) << HUE_W);
    end
    s = longint'(sat);
    l = longint'(lit);
    h = h % HUE_TURN;
    if (h < 0) begin
      h = h + HUE_TURN;
    end
    // chroma at scale one squared
    a = 2 * l - SL_ONE;
    if (a < 0) begin
      a = -a;
    end
    a = SL_ONE - a;
    c = a * s;
    // components at scale 2 * one^2 * sector width
    f = h % (2 * HUE_SECT);
    t = f - HUE_SECT;
    if (t < 0) begin
      t = -t;
    end
    cs = c * 2 * HUE_SECT;
    xs = c * (HUE_SECT - t) * 2;
    ms = 2 * l * SL_ONE * HUE_SECT - c * HUE_SECT;
    sector = 3'(h / HUE_SECT);
    case (sector)
      SEC_RED_YEL: begin
        res.red = channel_level(cs + ms);
        res.green = channel_level(xs + ms);
        res.blue = channel_level(ms);
      end
      SEC_YEL_GRN: begin
        res.red = channel_level(xs + ms);
        res.green = channel_level(cs + ms);
        res.blue = channel_level(ms);
      end
      SEC_GRN_CYN: begin
        res.red = channel_level(ms);
        res.green = channel_level(cs + ms);
        res.blue = channel_level(xs + ms);
      end
      SEC_CYN_BLU: begin
        res.red = channel_level(ms);
        res.green = channel_level(xs + ms);
        res.blue = channel_level(cs + ms);
      end
      SEC_BLU_MAG: begin
        res.red = channel_level(xs + ms);
        res.green = channel_level(ms);
        res.blue = channel_level(cs + ms);
      end
      default: begin
        res.red = channel_level(cs + ms);
        res.green = channel_level(ms);
        res.blue = channel_level(xs + ms);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_LOG) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end else if (pick < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_fraction();
    int pick;
    int corner [6] = '{0, 1, 512, 1023, 1024, 2047};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return $urandom_range(0, SL_ONE);
    end else if (pick < 80) begin
      return $urandom_range(0, (1 << SL_W) - 1);
    end
    return corner[$urandom_range(0, 5)];
  endfunction

  function automatic int pick_hue();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return int'($urandom_range(0, 3 * HUE_TURN - 1)) - HUE_TURN;
    end else if (pick < 80) begin
      return int'($urandom_range(0, (1 << HUE_W) - 1)) - (1 << (HUE_W - 1));
    end
    // near a sector boundary
    return (int'($urandom_range(0, 17)) - 6) * HUE_SECT + int'($urandom_range(0, 2)) - 1;
  endfunction

  task automatic send_color(input int hue, input int sat, input int lit, input bit known,
                            input rgb_t typed);
    logic [HUE_W-1:0] h_bits;
    logic [SL_W-1:0]  s_bits;
    logic [SL_W-1:0]  l_bits;
    h_bits = HUE_W'(hue);
    s_bits = SL_W'(sat);
    l_bits = SL_W'(lit);
    in_tdata <= {{PAD_W{1'b0}}, l_bits, s_bits, h_bits};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rgb_expected_q.push_back(known ? typed : hsl_to_rgb_predict(h_bits, s_bits, l_bits));
  endtask

  task automatic source_gap();
    int n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(30, 120);
      return;
    end
    n = idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin : rgb_sink
    bit held_long;
    int n;
    held_long = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if (!held_long && results_seen >= 300) begin
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_N) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (rgb_expected_q.size() == 0) begin
        report_mismatch("item with none pending, data", int'(out_tdata), -1);
      end else begin
        want = rgb_expected_q.pop_front();
        if (got.red !== want.red) begin
          report_mismatch("red", int'(got.red), int'(want.red));
        end
        if (got.green !== want.green) begin
          report_mismatch("green", int'(got.green), int'(want.green));
        end
        if (got.blue !== want.blue) begin
          report_mismatch("blue", int'(got.blue), int'(want.blue));
        end
      end
    end
  end

  initial begin : color_source
    rgb_t typed;
    wait (rst_n === 1'b1);
    @(posedge clk);
    foreach (color_rows[i]) begin
      typed.red = CH_W'(color_rows[i].red);
      typed.green = CH_W'(color_rows[i].green);
      typed.blue = CH_W'(color_rows[i].blue);
      send_color(color_rows[i].hue, color_rows[i].sat, color_rows[i].lit,
                 color_rows[i].known, typed);
      source_gap();
    end
    for (int i = 0; i < RAND_N; i++) begin
      if (i == RAND_N / 2) begin
        // let the pipeline drain completely
        in_tvalid <= 1'b0;
        while (rgb_expected_q.size() != 0) @(posedge clk);
      end
      send_color(pick_hue(), pick_fraction(), pick_fraction(), 1'b0, '0);
      source_gap();
    end
    in_tvalid <= 1'b0;
    while (rgb_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
